[hw/rtl/rffc_pkg.sv]
`default_nettype none

package rffc_pkg;

    localparam int unsigned MaxPayload = 125;
    localparam int unsigned MaxResults = 4;
    localparam int unsigned CntW       = $clog2(MaxResults + 1);

    localparam logic [15:0] CrcPolyNib = 16'h1081;
    localparam logic [3:0]  NibMask    = 4'hF;

    localparam logic       OP_START   = 1'b0;
    localparam logic       OP_PAYLOAD = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MODE    = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;
    localparam logic [1:0] ST_LENGTH  = 2'd3;

    localparam logic [1:0] REG_FRAME_TYPE = 2'd0;
    localparam logic [1:0] REG_ENABLED    = 2'd1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] frame_length;
        logic       direct_mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
        logic       run_last;
    } t_out_item;

    // one nibble step times 0x1081, reflected
    function automatic logic [15:0] crc_nib(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0]  q;
        logic [15:0] prod;
        q    = (crc[3:0] ^ nib) & NibMask;
        prod = ({12'd0, q} << 12) ^ ({12'd0, q} << 7) ^ {12'd0, q};
        return (crc >> 4) ^ (prod & {16{CrcPolyNib != 16'd0}});
    endfunction

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        return crc_nib(crc_nib(crc, b[3:0]), b[7:4]);
    endfunction

    function automatic t_out_item mk_res(input logic [7:0] b, input logic v,
                                         input logic e, input logic [1:0] st);
        t_out_item r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.frame_end  = e;
        r.status     = st;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/radio_frame_framer_crc16_core.sv]
// latency: first result of an item is shown the cycle after its input transfer
// throughput: one input item per cycle while each item gives at most one result and the
//   output is ready; an item giving more results holds the input while the result buffer drains
// reset: synchronous active-low i_rst_n clears config registers, frame state, crc and buffer count
`default_nettype none

module radio_frame_framer_crc16_core
    import rffc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic [7:0]  r_frame_type;
    logic        r_enabled;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_left,      n_left;
    logic        r_in_frame,  n_in_frame;
    logic        r_dropping,  n_dropping;
    logic [CntW-1:0] r_cnt;
    t_out_item   r_buf [MaxResults];

    t_out_item   res [MaxResults];
    logic [CntW-1:0] res_n;
    logic [1:0]  st;
    logic [7:0]  left_dec;
    logic        acc, pop;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt == '0) || ((r_cnt == CntW'(1)) && i_out_ready);
    assign acc         = i_in_valid && o_in_ready;
    assign left_dec    = r_left - 8'd1;

    always_comb begin
        n_crc      = r_crc;
        n_left     = r_left;
        n_in_frame = r_in_frame;
        n_dropping = r_dropping;
        res_n      = '0;
        st         = ST_OK;
        for (int k = 0; k < MaxResults; k++) begin
            res[k] = mk_res(8'd0, 1'b0, 1'b0, ST_OK);
        end
        if (i_in_data.opcode == OP_START) begin
            n_in_frame = 1'b0;
            n_dropping = 1'b0;
            n_crc      = 16'd0;
            n_left     = i_in_data.frame_length;
            if (!i_in_data.direct_mode) begin
                st = ST_MODE;
            end else if (!r_enabled) begin
                st = ST_STOPPED;
            end else if (i_in_data.frame_length > 8'(MaxPayload)) begin
                st = ST_LENGTH;
            end
            if (st != ST_OK) begin
                res[0]     = mk_res(8'd0, 1'b0, 1'b0, st);
                res_n      = CntW'(1);
                n_dropping = (i_in_data.frame_length != 8'd0);
            end else begin
                res[0] = mk_res(r_frame_type, 1'b1, 1'b0, ST_OK);
                res[1] = mk_res(i_in_data.frame_length + 8'd2, 1'b1, 1'b0, ST_OK);
                if (i_in_data.frame_length == 8'd0) begin
                    res[2] = mk_res(8'd0, 1'b1, 1'b0, ST_OK);
                    res[3] = mk_res(8'd0, 1'b1, 1'b1, ST_OK);
                    res_n  = CntW'(4);
                end else begin
                    res_n      = CntW'(2);
                    n_in_frame = 1'b1;
                end
            end
        end else if (r_in_frame) begin
            n_crc  = crc_fold(r_crc, i_in_data.data_byte);
            n_left = left_dec;
            res[0] = mk_res(i_in_data.data_byte, 1'b1, 1'b0, ST_OK);
            res_n  = CntW'(1);
            if (left_dec == 8'd0) begin
                res[1]     = mk_res(n_crc[7:0], 1'b1, 1'b0, ST_OK);
                res[2]     = mk_res(n_crc[15:8], 1'b1, 1'b1, ST_OK);
                res_n      = CntW'(3);
                n_in_frame = 1'b0;
            end
        end else if (r_dropping) begin
            n_left = left_dec;
            if (left_dec == 8'd0) begin
                n_dropping = 1'b0;
            end
        end
        for (int k = 0; k < MaxResults; k++) begin
            res[k].run_last = (res_n == CntW'(k + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= 8'd0;
            r_enabled    <= 1'b0;
            r_crc        <= 16'd0;
            r_left       <= 8'd0;
            r_in_frame   <= 1'b0;
            r_dropping   <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_FRAME_TYPE) begin
                    r_frame_type <= i_cfg_data;
                end else if (i_cfg_index == REG_ENABLED) begin
                    r_enabled <= i_cfg_data[0];
                end
            end
            if (acc) begin
                r_crc      <= n_crc;
                r_left     <= n_left;
                r_in_frame <= n_in_frame;
                r_dropping <= n_dropping;
                r_cnt      <= res_n;
            end else if (pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    // result buffer, head at entry 0
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int k = 0; k < MaxResults; k++) begin
                r_buf[k] <= res[k];
            end
        end else if (pop) begin
            for (int k = 0; k < MaxResults - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxResults))
        else $error("result count out of range");

    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (!o_out_data.byte_valid && o_out_data.run_last))
        else $error("status result carries a byte or is not last");

    a_state_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_frame && r_dropping))
        else $error("frame open while dropping");

    a_payload_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_data.opcode == OP_PAYLOAD && r_in_frame) |=>
        (o_out_valid && o_out_data.byte_valid))
        else $error("payload transfer gave no byte");

endmodule

`default_nettype wire
